FILE: src/first_fit_range_allocator_defines.svh
// ----------------------------------------------------------------------------
// first_fit_range_allocator_defines.svh
// Assertion macros for the range allocator.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_RANGE_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_RANGE_ALLOCATOR_DEFINES_SVH

`ifndef ASSERT_OFF
`define FFRA_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("ffra: assertion failed");
`define FFRA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ffra: assertion failed");
`else
`define FFRA_ASSERT(lbl, prop)
`define FFRA_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: src/ffra_pkg.sv
// ----------------------------------------------------------------------------
// ffra_pkg
// Types and codes shared by the range allocator.
// ----------------------------------------------------------------------------
package ffra_pkg;

	localparam int IDX_W     = 16;
	localparam int CFG_IDX_W = 1;

	localparam logic [1:0] OP_ALLOC   = 2'd0;
	localparam logic [1:0] OP_RELEASE = 2'd1;
	localparam logic [1:0] OP_DEFRAG  = 2'd2;
	localparam logic [1:0] OP_CLEAR   = 2'd3;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_GROWN      = 2'd1;
	localparam logic [1:0] ST_STATE_FULL = 2'd2;
	localparam logic [1:0] ST_LIST_FULL  = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_BASE_TOP    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STATE_LIMIT = 1'd1;

	typedef struct packed {
		logic [1:0]       op;
		logic [IDX_W-1:0] range_start;
		logic [IDX_W-1:0] range_size;
	} req_t;

	typedef struct packed {
		logic [IDX_W-1:0] given_index;
		logic [1:0]       status;
	} rsp_t;

	typedef struct packed {
		logic [IDX_W-1:0] start;
		logic [IDX_W-1:0] len;
	} entry_t;

endpackage

FILE: src/first_fit_range_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_range_allocator
// First-fit allocator of index ranges with a coalescing free list.
// ----------------------------------------------------------------------------
// Usage:
//   req (valid/stall) carries one request: allocate, release, defragment or
//   clear. rsp (valid/stall) returns exactly one result per request.
//   cfg_we/cfg_index/cfg_wdata write base_top (0) and state_limit (1); the
//   user must write them only while the block is idle (not enforced).
//   The free list sits in one single-port-read, single-port-write memory of
//   FREE_SLOTS entries with a registered read; every list step is a read,
//   then a check/write. Release and clear finish without a list pass;
//   allocate scans from the front and, on an exact fit, shifts the later
//   entries down; defragment runs bubble passes until one pass makes no
//   swap, then one merge pass.
//   One request is worked on at a time; the next is taken as soon as the
//   previous result is in the output register.
//   Reset empties the list and the growth count; no clearing pass is needed.
//   While rsp is stalled the result holds; a finished request waits until
//   the output register is free, and req stalls meanwhile.
// ----------------------------------------------------------------------------
`include "first_fit_range_allocator_defines.svh"

module first_fit_range_allocator #(
	parameter int FREE_SLOTS = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  ffra_pkg::req_t                 req,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output ffra_pkg::rsp_t                 rsp,
	input  logic                           cfg_we,
	input  logic [ffra_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ffra_pkg::IDX_W-1:0]     cfg_wdata
);
	import ffra_pkg::*;

	localparam int AW = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
	localparam int CW = $clog2(FREE_SLOTS + 1);

	typedef enum logic [4:0] {
		IDLE, A_RD, A_CHK, A_GROW, SH_RD, SH_WR,
		S_START, S_LD, S_RD, S_CMP, S_END,
		M_START, M_LD, M_RD, M_CMP, M_END, DONE
	} state_t;

	state_t           state_q;
	logic [1:0]       op_q;
	logic [IDX_W-1:0] size_q;
	logic [CW-1:0]    idx_q;
	logic [CW-1:0]    wr_idx_q;
	logic [CW-1:0]    cnt_q;
	logic [IDX_W-1:0] grown_q;
	logic [IDX_W-1:0] base_q;
	logic [IDX_W-1:0] limit_q;
	logic [IDX_W-1:0] given_q;
	logic [1:0]       status_q;
	logic             swap_q;
	entry_t           cur_q;
	rsp_t             rsp_q;
	logic             rsp_valid_q;

	entry_t mem [FREE_SLOTS];
	entry_t rd_q;

	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	entry_t        wr_data;

	logic              req_acc;
	logic              out_free;
	logic              is_last;
	logic [IDX_W-1:0]  new_len;
	logic [IDX_W:0]    top;
	logic [IDX_W+1:0]  need;
	logic [IDX_W:0]    end_sum;
	logic [IDX_W:0]    len_sum;
	logic              can_merge;
	logic              s_swap;
	logic [CW-1:0]     idx_m1;

	assign req_stall = (state_q != IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign is_last   = (idx_q + CW'(1) == cnt_q);
	assign idx_m1    = idx_q - CW'(1);
	assign new_len   = rd_q.len - size_q;
	assign top       = {1'b0, base_q} + {1'b0, grown_q};
	assign need      = {1'b0, top} + {2'b00, size_q};
	assign end_sum   = {1'b0, cur_q.start} + {1'b0, cur_q.len};
	assign len_sum   = {1'b0, cur_q.len} + {1'b0, rd_q.len};
	assign can_merge = ({1'b0, rd_q.start} == end_sum) && !len_sum[IDX_W];
	assign s_swap    = (cur_q.start > rd_q.start);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = idx_q[AW-1:0];
		wr_en   = 1'b0;
		wr_addr = idx_q[AW-1:0];
		wr_data = rd_q;
		case (state_q)
			IDLE: begin
				wr_addr = cnt_q[AW-1:0];
				wr_data = '{start: req.range_start, len: req.range_size};
				wr_en   = req_acc && (req.op == OP_RELEASE) && (cnt_q < CW'(FREE_SLOTS));
			end
			A_RD: rd_en = (idx_q != cnt_q);
			A_CHK: begin
				wr_data = '{start: rd_q.start + size_q, len: new_len};
				wr_en   = (rd_q.len >= size_q) && (new_len != '0);
			end
			SH_RD: begin
				rd_addr = AW'(idx_q + CW'(1));
				rd_en   = !is_last;
			end
			SH_WR: wr_en = 1'b1;
			S_START, M_START: begin
				rd_addr = '0;
				rd_en   = 1'b1;
			end
			S_RD, M_RD: rd_en = 1'b1;
			S_CMP: begin
				wr_addr = idx_m1[AW-1:0];
				wr_data = s_swap ? rd_q : cur_q;
				wr_en   = 1'b1;
			end
			S_END: begin
				wr_addr = idx_q[AW-1:0];
				wr_data = cur_q;
				wr_en   = 1'b1;
			end
			M_CMP: begin
				wr_addr = wr_idx_q[AW-1:0];
				wr_data = cur_q;
				wr_en   = !can_merge;
			end
			M_END: begin
				wr_addr = wr_idx_q[AW-1:0];
				wr_data = cur_q;
				wr_en   = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			cnt_q       <= '0;
			grown_q     <= '0;
			base_q      <= '0;
			limit_q     <= '1;
			rsp_valid_q <= 1'b0;
			idx_q       <= '0;
			wr_idx_q    <= '0;
			swap_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_BASE_TOP:    base_q  <= cfg_wdata;
					REG_STATE_LIMIT: limit_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (rsp_valid_q && !rsp_stall && (state_q != DONE)) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				IDLE: begin
					if (req_acc) begin
						op_q     <= req.op;
						size_q   <= req.range_size;
						given_q  <= '0;
						status_q <= ST_OK;
						idx_q    <= '0;
						state_q  <= DONE;
						case (req.op)
							OP_ALLOC: state_q <= A_RD;
							OP_RELEASE: begin
								if (cnt_q < CW'(FREE_SLOTS)) begin
									cnt_q <= cnt_q + CW'(1);
								end else begin
									status_q <= ST_LIST_FULL;
								end
							end
							OP_DEFRAG: begin
								if (cnt_q > CW'(1)) begin
									state_q <= S_START;
								end
							end
							OP_CLEAR: cnt_q <= '0;
							default: ;
						endcase
					end
				end
				A_RD: state_q <= (idx_q == cnt_q) ? A_GROW : A_CHK;
				A_CHK: begin
					if (rd_q.len >= size_q) begin
						given_q <= rd_q.start;
						state_q <= (new_len == '0) ? SH_RD : DONE;
					end else begin
						idx_q   <= idx_q + CW'(1);
						state_q <= A_RD;
					end
				end
				A_GROW: begin
					if (need > {1'b0, 1'b0, limit_q}) begin
						status_q <= ST_STATE_FULL;
					end else begin
						given_q  <= top[IDX_W-1:0];
						grown_q  <= grown_q + size_q;
						status_q <= ST_GROWN;
					end
					state_q <= DONE;
				end
				SH_RD: begin
					if (is_last) begin
						cnt_q   <= cnt_q - CW'(1);
						state_q <= DONE;
					end else begin
						state_q <= SH_WR;
					end
				end
				SH_WR: begin
					idx_q   <= idx_q + CW'(1);
					state_q <= SH_RD;
				end
				S_START: begin
					swap_q  <= 1'b0;
					state_q <= S_LD;
				end
				S_LD: begin
					cur_q   <= rd_q;
					idx_q   <= CW'(1);
					state_q <= S_RD;
				end
				S_RD: state_q <= S_CMP;
				S_CMP: begin
					if (s_swap) begin
						swap_q <= 1'b1;
					end else begin
						cur_q <= rd_q;
					end
					if (is_last) begin
						state_q <= S_END;
					end else begin
						idx_q   <= idx_q + CW'(1);
						state_q <= S_RD;
					end
				end
				S_END: state_q <= swap_q ? S_START : M_START;
				M_START: state_q <= M_LD;
				M_LD: begin
					cur_q    <= rd_q;
					idx_q    <= CW'(1);
					wr_idx_q <= '0;
					state_q  <= M_RD;
				end
				M_RD: state_q <= M_CMP;
				M_CMP: begin
					if (can_merge) begin
						cur_q.len <= len_sum[IDX_W-1:0];
					end else begin
						wr_idx_q <= wr_idx_q + CW'(1);
						cur_q    <= rd_q;
					end
					if (is_last) begin
						state_q <= M_END;
					end else begin
						idx_q   <= idx_q + CW'(1);
						state_q <= M_RD;
					end
				end
				M_END: begin
					cnt_q   <= wr_idx_q + CW'(1);
					state_q <= DONE;
				end
				DONE: begin
					if (out_free) begin
						rsp_q       <= '{given_index: given_q, status: status_q};
						rsp_valid_q <= 1'b1;
						state_q     <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	`FFRA_ASSERT(a_cnt_bound, (cnt_q <= CW'(FREE_SLOTS)))
	`FFRA_ASSERT_NEXT(a_busy_after_req, req_acc, state_q != IDLE)
	`FFRA_ASSERT_NEXT(a_rsp_from_done, (state_q != DONE) && !rsp_valid_q, !rsp_valid_q)
	`FFRA_ASSERT_NEXT(a_grow_only_alloc, (state_q == A_GROW), op_q == OP_ALLOC)

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Bench for the first-fit range allocator.
// Directed table: empty-list growth, zero sizes, wrap of a block start,
// merge overflow, equal starts, a full state vector; a directed run then
// fills the free list. Random phases with different base/limit settings
// follow. Results are checked against the table or a bench model.
// Random req gaps and rsp stalls; one long output hold fills the block.
// ----------------------------------------------------------------------------
module tb_top;
	import ffra_pkg::*;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 req_valid = 1'b0;
	logic                 req_stall;
	req_t                 req = '0;
	logic                 rsp_valid;
	logic                 rsp_stall = 1'b0;
	rsp_t                 rsp;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [IDX_W-1:0]     cfg_wdata = '0;

	first_fit_range_allocator dut (.*);

	always #2 clk = ~clk;

	localparam int SLOTS = 32;

	// free-list model
	logic [IDX_W-1:0] blk_start [SLOTS];
	logic [IDX_W-1:0] blk_len [SLOTS];
	int               blk_cnt;
	logic [IDX_W-1:0] grown;
	logic [IDX_W-1:0] base_top;
	logic [IDX_W-1:0] state_limit;

	rsp_t  pending_rsp [$];
	int    errors = 0;
	bit    idle_on = 1'b1;
	bit    long_hold = 1'b0;

	function automatic void drop_block(int pos);
		for (int k = pos; k + 1 < blk_cnt; k++) begin
			blk_start[k] = blk_start[k + 1];
			blk_len[k] = blk_len[k + 1];
		end
		blk_cnt--;
	endfunction

	function automatic rsp_t allocator_step(req_t r);
		rsp_t o;
		int   top;
		logic [IDX_W-1:0] s, l;
		int   j;
		o = '0;
		o.status = ST_OK;
		case (r.op)
			OP_ALLOC: begin
				for (int i = 0; i < blk_cnt; i++) begin
					if (blk_len[i] >= r.range_size) begin
						o.given_index = blk_start[i];
						blk_start[i] = blk_start[i] + r.range_size;
						blk_len[i] = blk_len[i] - r.range_size;
						if (blk_len[i] == 0)
							drop_block(i);
						return o;
					end
				end
				top = int'(base_top) + int'(grown);
				if (top + int'(r.range_size) > int'(state_limit)) begin
					o.status = ST_STATE_FULL;
				end else begin
					o.given_index = top[IDX_W-1:0];
					grown = grown + r.range_size;
					o.status = ST_GROWN;
				end
			end
			OP_RELEASE: begin
				if (blk_cnt >= SLOTS) begin
					o.status = ST_LIST_FULL;
				end else begin
					blk_start[blk_cnt] = r.range_start;
					blk_len[blk_cnt] = r.range_size;
					blk_cnt++;
				end
			end
			OP_DEFRAG: begin
				for (int i = 1; i < blk_cnt; i++) begin
					s = blk_start[i];
					l = blk_len[i];
					j = i;
					while (j > 0 && blk_start[j - 1] > s) begin
						blk_start[j] = blk_start[j - 1];
						blk_len[j] = blk_len[j - 1];
						j--;
					end
					blk_start[j] = s;
					blk_len[j] = l;
				end
				for (int i = 0; i < blk_cnt; i++) begin
					while (i + 1 < blk_cnt &&
						int'(blk_start[i + 1]) == int'(blk_start[i]) + int'(blk_len[i]) &&
						int'(blk_len[i]) + int'(blk_len[i + 1]) <= 65535) begin
						blk_len[i] = blk_len[i] + blk_len[i + 1];
						drop_block(i + 1);
					end
				end
			end
			default: blk_cnt = 0;
		endcase
		return o;
	endfunction

	task automatic issue(input req_t r, input bit typed, input rsp_t typed_rsp);
		logic st;
		rsp_t p;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do begin
			@(negedge clk);
			st = req_stall;
			@(posedge clk);
		end while (st);
		p = allocator_step(r);
		pending_rsp.insert(pending_rsp.size(), typed ? typed_rsp : p);
	endtask

	task automatic issue_pred(input logic [1:0] op, input int s, input int z);
		req_t r;
		r.op = op;
		r.range_start = s[IDX_W-1:0];
		r.range_size = z[IDX_W-1:0];
		issue(r, 1'b0, '0);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		wait (pending_rsp.size() == 0);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [IDX_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_BASE_TOP)
			base_top = v;
		else
			state_limit = v;
	endtask

	task automatic set_config(input logic [IDX_W-1:0] b, input logic [IDX_W-1:0] l);
		drain();
		write_reg(REG_BASE_TOP, b);
		write_reg(REG_STATE_LIMIT, l);
	endtask

	task automatic random_requests(input int n, input int size_cap);
		int  u, z, s;
		for (int k = 0; k < n; k++) begin
			u = $urandom_range(0, 99);
			case ($urandom_range(0, 9))
				0: z = $urandom_range(0, 65535);
				1: z = ($urandom_range(0, 1) != 0) ? 0 : 65535;
				default: z = $urandom_range(0, size_cap);
			endcase
			if ($urandom_range(0, 3) == 0)
				s = $urandom_range(0, 65535);
			else
				s = int'(base_top) + $urandom_range(0, 2000);
			if (u < 45)
				issue_pred(OP_ALLOC, $urandom_range(0, 65535), z);
			else if (u < 88)
				issue_pred(OP_RELEASE, s, z);
			else if (u < 97)
				issue_pred(OP_DEFRAG, $urandom_range(0, 65535), $urandom_range(0, 65535));
			else
				issue_pred(OP_CLEAR, $urandom_range(0, 65535), $urandom_range(0, 65535));
		end
	endtask

	typedef struct {
		logic [1:0] op;
		int         s;
		int         z;
		bit         typed;
		int         given;
		logic [1:0] status;
	} row_t;

	row_t table_rows [] = '{
		'{OP_ALLOC,   0,     0,     1, 0, ST_GROWN},
		'{OP_ALLOC,   0,     10,    1, 0, ST_GROWN},
		'{OP_RELEASE, 100,   5,     1, 0, ST_OK},
		'{OP_RELEASE, 105,   65535, 1, 0, ST_OK},
		'{OP_RELEASE, 50,    20,    1, 0, ST_OK},
		'{OP_DEFRAG,  0,     0,     1, 0, ST_OK},
		'{OP_ALLOC,   0,     0,     0, 0, ST_OK},
		'{OP_ALLOC,   0,     20,    0, 0, ST_OK},
		'{OP_ALLOC,   0,     65535, 0, 0, ST_OK},
		'{OP_RELEASE, 65530, 10,    1, 0, ST_OK},
		'{OP_ALLOC,   0,     8,     0, 0, ST_OK},
		'{OP_ALLOC,   0,     2,     0, 0, ST_OK},
		'{OP_CLEAR,   65535, 65535, 1, 0, ST_OK},
		'{OP_RELEASE, 7,     3,     1, 0, ST_OK},
		'{OP_RELEASE, 7,     1,     1, 0, ST_OK},
		'{OP_RELEASE, 4,     3,     1, 0, ST_OK},
		'{OP_DEFRAG,  0,     0,     1, 0, ST_OK},
		'{OP_ALLOC,   0,     6,     0, 0, ST_OK},
		'{OP_ALLOC,   0,     65535, 1, 0, ST_STATE_FULL},
		'{OP_CLEAR,   0,     0,     1, 0, ST_OK}
	};

	// response checker: sampled mid-cycle, accepted at the next rising edge
	always @(negedge clk) begin
		rsp_t e;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0) begin
				$error("unexpected response: given_index %0d status %0d",
					rsp.given_index, rsp.status);
				errors++;
			end else begin
				e = pending_rsp.pop_front();
				if (rsp.given_index !== e.given_index) begin
					$error("given_index: expected %0d, actual %0d", e.given_index,
						rsp.given_index);
					errors++;
				end
				if (rsp.status !== e.status) begin
					$error("status: expected %0d, actual %0d", e.status, rsp.status);
					errors++;
				end
			end
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (long_hold) begin
				long_hold = 1'b0;
				rsp_stall <= 1'b1;
				repeat (400) @(posedge clk);
				rsp_stall <= 1'b0;
			end else if (idle_on && $urandom_range(0, 9) == 0) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				rsp_stall <= 1'b0;
			end
		end
	end

	initial begin
		#100ms;
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		rsp_t t;
		req_t r;
		blk_cnt = 0;
		grown = '0;
		base_top = '0;
		state_limit = 16'hFFFF;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (table_rows[i]) begin
			r.op = table_rows[i].op;
			r.range_start = table_rows[i].s[IDX_W-1:0];
			r.range_size = table_rows[i].z[IDX_W-1:0];
			t.given_index = table_rows[i].given[IDX_W-1:0];
			t.status = table_rows[i].status;
			issue(r, table_rows[i].typed, t);
		end
		for (int k = 0; k < SLOTS; k++)
			issue_pred(OP_RELEASE, 1000 + 4 * k, 2);
		r.op = OP_RELEASE;
		r.range_start = 16'hFFFF;
		r.range_size = 16'hFFFF;
		issue(r, 1'b1, '{given_index: '0, status: ST_LIST_FULL});
		issue_pred(OP_DEFRAG, 0, 0);

		set_config(16'hFFFF, 16'hFFFF);
		issue_pred(OP_CLEAR, 0, 0);
		issue_pred(OP_ALLOC, 0, 0);
		issue_pred(OP_ALLOC, 0, 1);
		random_requests(40, 64);

		set_config(16'h0000, 16'h0000);
		issue_pred(OP_ALLOC, 0, 0);
		issue_pred(OP_ALLOC, 0, 1);
		random_requests(300, 64);

		set_config(16'd300, 16'd4000);
		long_hold = 1'b1;
		random_requests(300, 200);
		req_valid <= 1'b0;
		wait (pending_rsp.size() == 0);
		@(posedge clk);

		set_config(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
		random_requests(300, 64);

		set_config(16'd0, 16'hFFFF);
		random_requests(200, 64);
		idle_on = 1'b0;
		random_requests(130, 64);

		req_valid <= 1'b0;
		wait (pending_rsp.size() == 0);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule

FILE: first_fit_range_allocator.f
+incdir+src
src/ffra_pkg.sv
src/first_fit_range_allocator.sv
bench/tb_top.sv
